/* sv/user_segment_limit_unit_macros.svh */
// ----------------------------------------------------------------------------
// User segment limit unit: assertion macros
// Concurrent checks on clk with synchronous reset rst.
// ----------------------------------------------------------------------------
`ifndef USER_SEGMENT_LIMIT_UNIT_MACROS_SVH
`define USER_SEGMENT_LIMIT_UNIT_MACROS_SVH

// Implication in the same cycle.
`define USL_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication in the next cycle.
`define USL_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/usl_pkg.sv */
// ----------------------------------------------------------------------------
// User segment limit unit: package
// Widths, opcodes, register indexes and alignment constants.
// ----------------------------------------------------------------------------
`default_nettype none

package usl_pkg;

  localparam int OPCODE_W    = 3;
  localparam int ADDR_W      = 32;
  localparam int CFG_INDEX_W = 2;

  localparam int ALIGN_LOG2 = 12;
  localparam logic [ADDR_W-1:0] ALIGN_UNIT = ADDR_W'(1) << ALIGN_LOG2;
  localparam logic [ADDR_W-1:0] ALIGN_MASK = ALIGN_UNIT - ADDR_W'(1);

  localparam logic [OPCODE_W-1:0] OP_CHECK     = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_GROW_CODE = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_GROW_DATA = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_TRACK     = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_RESET     = 3'd4;

  localparam logic [CFG_INDEX_W-1:0] CFG_PHYS_OFFSET  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_POOL_SIZE    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_STACK_BOTTOM = 2'd2;

  localparam logic [ADDR_W-1:0] RST_PHYS_OFFSET  = 32'h0040_0000;
  localparam logic [ADDR_W-1:0] RST_POOL_SIZE    = 32'h0040_0000;
  localparam logic [ADDR_W-1:0] RST_STACK_BOTTOM = 32'h003F_0000;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [ADDR_W-1:0]   address;
    logic [ADDR_W-1:0]   length;
  } req_word_t;

  function automatic logic [ADDR_W-1:0] round_up(input logic [ADDR_W-1:0] v);
    return (v + ALIGN_MASK) & ~ALIGN_MASK;
  endfunction

endpackage

`default_nettype wire

/* sv/usl_req_if.sv */
// ----------------------------------------------------------------------------
// User segment limit unit: request channel
// Valid/ready channel carrying opcode, address and length.
// ----------------------------------------------------------------------------
`default_nettype none

interface usl_req_if;
  import usl_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [ADDR_W-1:0]   address;
  logic [ADDR_W-1:0]   length;

  modport source (output valid, opcode, address, length, input ready);
  modport sink   (input valid, opcode, address, length, output ready);
endinterface

`default_nettype wire

/* sv/usl_rsp_if.sv */
// ----------------------------------------------------------------------------
// User segment limit unit: result channel
// Valid/ready channel carrying the check result and the state after a step.
// ----------------------------------------------------------------------------
`default_nettype none

interface usl_rsp_if;
  import usl_pkg::*;

  logic              valid;
  logic              ready;
  logic              is_user;
  logic [ADDR_W-1:0] phys_address;
  logic              status;
  logic [ADDR_W-1:0] code_limit_now;
  logic [ADDR_W-1:0] data_limit_now;
  logic [ADDR_W-1:0] region_start_now;
  logic [ADDR_W-1:0] region_size_now;

  modport source (output valid, is_user, phys_address, status, code_limit_now,
                  data_limit_now, region_start_now, region_size_now,
                  input ready);
  modport sink   (input valid, is_user, phys_address, status, code_limit_now,
                  data_limit_now, region_start_now, region_size_now,
                  output ready);
endinterface

`default_nettype wire

/* sv/user_segment_limit_unit.sv */
// ----------------------------------------------------------------------------
// User segment limit unit
// Checks and translates user addresses, grows code and data limits and
// tracks one user region; a reset opcode restores the limits and region.
// ----------------------------------------------------------------------------
// One request word is taken per cycle unless a waiting result holds the input
// register. A word is first captured in the input register; the check, grow,
// track or reset logic then runs in a single pass, the limit and region
// registers are updated and the result word is loaded into the output
// register, from which the result is offered, and each result carries the
// state after its own step. Requests keep being taken while a result waits,
// until both registers are full. Configuration writes take effect at the
// next edge and are meant for when the unit is idle.
`default_nettype none

`include "user_segment_limit_unit_macros.svh"

module user_segment_limit_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [usl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [usl_pkg::ADDR_W-1:0]      cfg_data,
  usl_req_if.sink                              req,
  usl_rsp_if.source                            rsp
);
  import usl_pkg::*;

  logic [ADDR_W-1:0] phys_offset;
  logic [ADDR_W-1:0] pool_size;
  logic [ADDR_W-1:0] stack_bottom;

  logic [ADDR_W-1:0] code_limit, code_limit_next;
  logic [ADDR_W-1:0] data_limit, data_limit_next;
  logic [ADDR_W-1:0] region_start, region_start_next;
  logic [ADDR_W-1:0] region_size, region_size_next;

  logic      s1_valid;
  req_word_t s1_word;
  logic      advance;

  logic              out_valid;
  logic              out_is_user, is_user_next;
  logic [ADDR_W-1:0] out_phys, phys_next;
  logic              out_status, status_next;

  assign advance   = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      phys_offset  <= RST_PHYS_OFFSET;
      pool_size    <= RST_POOL_SIZE;
      stack_bottom <= RST_STACK_BOTTOM;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PHYS_OFFSET:  phys_offset  <= cfg_data;
        CFG_POOL_SIZE:    pool_size    <= cfg_data;
        CFG_STACK_BOTTOM: stack_bottom <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_word <= '{opcode: req.opcode, address: req.address, length: req.length};
    end
  end

  always_comb begin
    logic [ADDR_W-1:0] code_end;
    logic [ADDR_W-1:0] span_end;
    logic [ADDR_W-1:0] a_start;
    logic [ADDR_W-1:0] cur_end;
    logic [ADDR_W-1:0] new_start;
    logic [ADDR_W-1:0] top;

    code_limit_next   = code_limit;
    data_limit_next   = data_limit;
    region_start_next = region_start;
    region_size_next  = region_size;
    is_user_next      = 1'b0;
    phys_next         = '0;
    status_next       = 1'b0;

    code_end  = round_up(s1_word.address);
    span_end  = round_up(s1_word.address + s1_word.length);
    a_start   = s1_word.address & ~ALIGN_MASK;
    cur_end   = region_start + region_size;
    new_start = (a_start < region_start) ? a_start : region_start;
    top       = (span_end > cur_end) ? span_end : cur_end;

    case (s1_word.opcode)
      OP_CHECK: begin
        is_user_next = (s1_word.address < pool_size) &&
                       ((s1_word.address < code_limit) ||
                        (s1_word.address < data_limit) ||
                        (s1_word.address >= stack_bottom));
        phys_next = (s1_word.address == '0) ? '0 : phys_offset + s1_word.address;
      end
      OP_GROW_CODE: begin
        if (code_end == '0) begin
          code_end = ALIGN_UNIT;
        end
        if (code_end > stack_bottom) begin
          status_next = 1'b1;
        end else if (code_end > code_limit) begin
          code_limit_next = code_end;
        end
      end
      OP_GROW_DATA: begin
        if (span_end > stack_bottom) begin
          status_next = 1'b1;
        end else if (span_end > data_limit) begin
          data_limit_next = span_end;
        end
      end
      OP_TRACK: begin
        if (span_end > a_start) begin
          if (region_start == '0 && region_size == '0) begin
            region_start_next = a_start;
            region_size_next  = span_end - a_start;
          end else begin
            region_start_next = new_start;
            region_size_next  = top - new_start;
          end
        end
      end
      OP_RESET: begin
        code_limit_next   = ALIGN_UNIT;
        data_limit_next   = ALIGN_UNIT;
        region_start_next = '0;
        region_size_next  = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_limit   <= ALIGN_UNIT;
      data_limit   <= ALIGN_UNIT;
      region_start <= '0;
      region_size  <= '0;
    end else if (advance) begin
      code_limit   <= code_limit_next;
      data_limit   <= data_limit_next;
      region_start <= region_start_next;
      region_size  <= region_size_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_is_user <= is_user_next;
      out_phys    <= phys_next;
      out_status  <= status_next;
    end
  end

  // limits and region are only written on advance, so they match the word held
  assign rsp.valid            = out_valid;
  assign rsp.is_user          = out_is_user;
  assign rsp.phys_address     = out_phys;
  assign rsp.status           = out_status;
  assign rsp.code_limit_now   = code_limit;
  assign rsp.data_limit_now   = data_limit;
  assign rsp.region_start_now = region_start;
  assign rsp.region_size_now  = region_size;

  `USL_ASSERT_SAME(a_stall_holds, s1_valid && out_valid && !rsp.ready, !req.ready, "input stage not held while result stalled")
  `USL_ASSERT_NEXT(a_code_monotone, !(advance && s1_word.opcode == OP_RESET), code_limit >= $past(code_limit), "code limit fell without reset opcode")
  `USL_ASSERT_SAME(a_limits_aligned, 1'b1, ((code_limit & ALIGN_MASK) == '0) && ((data_limit & ALIGN_MASK) == '0), "segment limit not aligned")

endmodule

`default_nettype wire
